>>> src/lsbht_pkg.sv
// ----------------------------------------------------------------------------
// lsbht_pkg
// Shared types and constants for the line segment / box hit test.
// ----------------------------------------------------------------------------
package lsbht_pkg;

    // Bit positions in the edge mask
    localparam int unsigned EDGE_TOP    = 0;
    localparam int unsigned EDGE_BOTTOM = 1;
    localparam int unsigned EDGE_LEFT   = 2;
    localparam int unsigned EDGE_RIGHT  = 3;

    localparam int unsigned EDGE_COUNT  = 4;

    // Result of one test, as it leaves the compare logic
    typedef struct packed {
        logic [EDGE_COUNT-1:0] edge_hits;
        logic                  hit;
    } t_hit_result;

    // Output beat width: hit + edge mask, rounded up to whole bytes
    localparam int unsigned RESULT_BITS = 1 + EDGE_COUNT;
    localparam int unsigned OUT_TDATA_W = ((RESULT_BITS + 7) / 8) * 8;

endpackage

>>> src/lsbht_hit_calc.sv
// ----------------------------------------------------------------------------
// lsbht_hit_calc
// Edge crossing compare: forms the box edges and segment ends in doubled
// units and checks the two vertical edges against the horizontal segment.
// ----------------------------------------------------------------------------
module lsbht_hit_calc #(
    parameter int COORD_BITS = 24
) (
    input  logic [COORD_BITS-1:0] i_line_center_x,
    input  logic [COORD_BITS-1:0] i_line_center_y,
    input  logic [COORD_BITS-2:0] i_line_length,
    input  logic [COORD_BITS-1:0] i_box_center_x,
    input  logic [COORD_BITS-1:0] i_box_center_y,
    input  logic [COORD_BITS-2:0] i_box_width,
    input  logic [COORD_BITS-2:0] i_box_height,
    output lsbht_pkg::t_hit_result o_result
);

    // doubled coordinate is COORD_BITS+1, +/- a length needs one more, plus margin
    localparam int EW = COORD_BITS + 3;

    logic signed [EW-1:0] lx, ly, bx, by;
    logic signed [EW-1:0] len, wd, ht;
    logic signed [EW-1:0] xlo, xhi, ylo, yhi, e_left, e_right;
    logic                 span_ok, y_in;
    logic                 hit_left, hit_right;
    logic [lsbht_pkg::EDGE_COUNT-1:0] mask;

    assign lx  = $signed({{2{i_line_center_x[COORD_BITS-1]}}, i_line_center_x, 1'b0});
    assign ly  = $signed({{2{i_line_center_y[COORD_BITS-1]}}, i_line_center_y, 1'b0});
    assign bx  = $signed({{2{i_box_center_x[COORD_BITS-1]}}, i_box_center_x, 1'b0});
    assign by  = $signed({{2{i_box_center_y[COORD_BITS-1]}}, i_box_center_y, 1'b0});
    assign len = $signed({4'b0000, i_line_length});
    assign wd  = $signed({4'b0000, i_box_width});
    assign ht  = $signed({4'b0000, i_box_height});

    assign xlo     = lx - len;
    assign xhi     = lx + len;
    assign ylo     = by - ht;
    assign yhi     = by + ht;
    assign e_left  = bx - wd;
    assign e_right = bx + wd;

    // zero length or zero height: never a hit
    assign span_ok = (i_line_length != '0) && (i_box_height != '0);
    assign y_in    = (ylo <= ly) && (ly <= yhi);

    assign hit_left  = span_ok && y_in && (xlo <= e_left)  && (e_left  <= xhi);
    assign hit_right = span_ok && y_in && (xlo <= e_right) && (e_right <= xhi);

    always_comb begin
        mask = '0;
        // top and bottom run parallel to the segment
        mask[lsbht_pkg::EDGE_TOP]    = 1'b0;
        mask[lsbht_pkg::EDGE_BOTTOM] = 1'b0;
        mask[lsbht_pkg::EDGE_LEFT]   = hit_left;
        mask[lsbht_pkg::EDGE_RIGHT]  = hit_right;
    end

    assign o_result.edge_hits = mask;
    assign o_result.hit       = |mask;

endmodule

>>> src/line_segment_box_hit_test.sv
// ----------------------------------------------------------------------------
// line_segment_box_hit_test
// Tests a horizontal line segment against the edges of an axis-aligned box.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. The block takes a new beat every cycle while
// the output is not stalled, and holds it in the input register and then in
// the result register, with the compare logic in between. A stall on the
// output holds both stages; the input side keeps accepting while the input
// stage is empty or moving. Only the left and right edges can be crossed by
// a horizontal segment, so edge_hits bits for top and bottom are always zero.
// Touching an edge or a corner counts as a hit; a zero-length segment or a
// zero-height box never hits.
module line_segment_box_hit_test #(
    parameter int COORD_BITS = 24,
    localparam int IN_BITS    = 4 * COORD_BITS + 3 * (COORD_BITS - 1),
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // line_center_x, line_center_y, line_length, box_center_x, box_center_y,
    // box_width, box_height (lowest bit up), zero padded
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,

    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // hit, edge_hits (lowest bit up), zero padded
    output logic [lsbht_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int CB         = COORD_BITS;
    localparam int LB         = COORD_BITS - 1;

    localparam int O_LCX = 0;
    localparam int O_LCY = O_LCX + CB;
    localparam int O_LEN = O_LCY + CB;
    localparam int O_BCX = O_LEN + LB;
    localparam int O_BCY = O_BCX + CB;
    localparam int O_BW  = O_BCY + CB;
    localparam int O_BH  = O_BW + LB;

    logic                  r_s1_valid, n_s1_valid;
    logic                  r_s2_valid, n_s2_valid;
    logic [CB-1:0]         r_lcx, r_lcy, r_bcx, r_bcy;
    logic [LB-1:0]         r_len, r_bw, r_bh;
    lsbht_pkg::t_hit_result r_result;
    lsbht_pkg::t_hit_result calc_result;

    logic adv2, adv1, take_in;

    assign adv2    = !r_s2_valid || i_m_tready;
    assign adv1    = !r_s1_valid || adv2;
    assign take_in = i_s_tvalid && adv1;

    assign o_s_tready = adv1;

    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s2_valid = r_s2_valid;
        if (adv2) begin
            n_s2_valid = r_s1_valid;
        end
        if (adv1) begin
            n_s1_valid = i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_lcx <= i_s_tdata[O_LCX +: CB];
            r_lcy <= i_s_tdata[O_LCY +: CB];
            r_len <= i_s_tdata[O_LEN +: LB];
            r_bcx <= i_s_tdata[O_BCX +: CB];
            r_bcy <= i_s_tdata[O_BCY +: CB];
            r_bw  <= i_s_tdata[O_BW  +: LB];
            r_bh  <= i_s_tdata[O_BH  +: LB];
        end
    end

    lsbht_hit_calc #(
        .COORD_BITS (COORD_BITS)
    ) u_calc (
        .i_line_center_x (r_lcx),
        .i_line_center_y (r_lcy),
        .i_line_length   (r_len),
        .i_box_center_x  (r_bcx),
        .i_box_center_y  (r_bcy),
        .i_box_width     (r_bw),
        .i_box_height    (r_bh),
        .o_result        (calc_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (adv2 && r_s1_valid) begin
            r_result <= calc_result;
        end
    end

    assign o_m_tvalid = r_s2_valid;
    assign o_m_tdata  = {{(lsbht_pkg::OUT_TDATA_W - lsbht_pkg::RESULT_BITS){1'b0}},
                         r_result.edge_hits, r_result.hit};

endmodule
